FILE: rtl/core/radix2_fft_frame_macros.svh
// Assertion macros used by the checker file of the FFT block.
`ifndef RADIX2_FFT_FRAME_MACROS_SVH
`define RADIX2_FFT_FRAME_MACROS_SVH

// A property that is checked only while the block is out of reset.
`define R2F_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A property that is checked at every edge, during reset too.
`define R2F_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/r2f_pkg.sv
package r2f_pkg;

	localparam int MAX_LG = 10;
	localparam int SAMPLE_BITS = 16;
	localparam int OUT_BITS = SAMPLE_BITS + MAX_LG;
	localparam int LG_BITS = 4;
	localparam int HALF_BITS = MAX_LG - 1;
	localparam int ADDR_BITS = MAX_LG + 1;
	localparam int WORD_BITS = 2 * OUT_BITS;
	localparam int TW_BITS = 16;
	localparam int TW_DEPTH = 1 << HALF_BITS;
	localparam int TW_PH_STEP = 32768 / TW_DEPTH;
	localparam int PROD_BITS = TW_BITS + OUT_BITS;
	localparam int T_BITS = PROD_BITS + 1 - 15;
	localparam int TDATA_IN_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int TDATA_OUT_BITS = ((2 * OUT_BITS + MAX_LG + 7) / 8) * 8;
	localparam longint TWO_PI_Q30 = 64'sd6746518852;

	typedef logic signed [TW_BITS-1:0] tw_t;
	typedef tw_t tw_tab_t [TW_DEPTH];

	// Load strobes for the butterfly datapath.
	typedef struct packed {
		logic ld_b;
		logic ld_a;
		logic sum;
	} bf_ctl_t;

	function automatic longint q30_mul(input longint a, input longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic longint q30_to_q15(input longint v);
		longint q;
		q = (v + 16384) >>> 15;
		return (q > 32767) ? 64'sd32767 : q;
	endfunction

	// Builds the cosine or sine half of the twiddle ROM at elaboration.
	function automatic tw_tab_t tw_build(input bit want_sin);
		tw_tab_t tab;
		longint p, r, x, p2, p3, p4, p5, p6, p7, p8, p9;
		longint cv, sv, cr, sr, c, s;
		for (int k = 0; k < TW_DEPTH; k++) begin
			p = longint'(k) * TW_PH_STEP;
			r = p & 64'h3FFF;
			x = (((r > 64'h2000) ? (64'h4000 - r) : r) * TWO_PI_Q30 + 32768) >>> 16;
			p2 = q30_mul(x, x);
			p3 = q30_mul(p2, x);
			p4 = q30_mul(p2, p2);
			p5 = q30_mul(p4, x);
			p6 = q30_mul(p4, p2);
			p7 = q30_mul(p6, x);
			p8 = q30_mul(p4, p4);
			p9 = q30_mul(p8, x);
			cv = q30_to_q15((64'sd1 <<< 30) - p2 / 2 + p4 / 24 - p6 / 720 + p8 / 40320);
			sv = q30_to_q15(x - p3 / 6 + p5 / 120 - p7 / 5040 + p9 / 362880);
			cr = (r > 64'h2000) ? sv : cv;
			sr = (r > 64'h2000) ? cv : sv;
			c = p[14] ? -sr : cr;
			s = p[14] ? cr : sr;
			tab[k] = want_sin ? tw_t'(s) : tw_t'(c);
		end
		return tab;
	endfunction

	// Saturates a grown butterfly result to the output width.
	function automatic logic [OUT_BITS-1:0] sat_out(input logic [T_BITS:0] v);
		if (v[T_BITS:OUT_BITS-1] == '0 || v[T_BITS:OUT_BITS-1] == '1)
			return v[OUT_BITS-1:0];
		return v[T_BITS] ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
	endfunction

endpackage

FILE: rtl/core/radix2_fft_frame.sv
// Framed radix-2 decimation-in-time FFT, 16-bit complex in, 26-bit bins out.
// Input stream s_*: one complex sample per request, natural order. Samples
// are stored bit-reversed into the filling bank of a two-bank sample RAM.
// Output stream m_*: during frame k+1 every input request returns bin i of
// frame k, with its index and tlast on the final bin. Frame 0 returns nothing.
// Each bin is read from the other bank on its input request and is loaded
// into the output register in ST_OUT; no sample is taken in ST_OUT. After
// the last sample of a frame the in-place transform runs, N/2*log2(N)
// butterflies through ST_RD_B to ST_WR_I (read b, read a, multiply, round,
// write two words through the single write port); s_tready is low meanwhile.
// Reset clears the framing state and sets log2_points to 10; RAM contents
// are not cleared and need no clearing pass. A cfg write restarts framing.
// When the receiver stalls, the bin waits in the output register and no new
// sample is taken until it is gone or leaves in the same cycle.
module radix2_fft_frame (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// sample_re [15:0], sample_im [31:16]
	input  logic [r2f_pkg::TDATA_IN_BITS-1:0]  s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// bin_re [25:0], bin_im [51:26], bin_index [61:52], zero fill
	output logic [r2f_pkg::TDATA_OUT_BITS-1:0] m_tdata,
	output logic                               m_tlast,
	input  logic                               cfg_wen,
	input  logic [r2f_pkg::LG_BITS-1:0]        cfg_wdata
);
	import r2f_pkg::*;

	localparam tw_tab_t TW_COS = tw_build(1'b0);
	localparam tw_tab_t TW_SIN = tw_build(1'b1);
	localparam logic [LG_BITS-1:0] LG_MAX = LG_BITS'(MAX_LG);

	typedef enum logic [2:0] {
		ST_IDLE, ST_OUT, ST_RD_B, ST_RD_A, ST_MUL, ST_SUM, ST_WR_J, ST_WR_I
	} state_t;

	state_t state_q;
	logic [LG_BITS-1:0] lg_q, xs_q;
	logic [MAX_LG-1:0] fill_q, idx_s1, rev, rev_sh, nmask, ii, jj;
	logic [HALF_BITS-1:0] bf_q, kmask, kk, tw_idx;
	logic bank_q, xbank_q, have_q, prod_s1, last_s1, go_xf_q;
	logic accept, fill_last, half_last, stage_last;
	tw_t tw_cos_q, tw_sin_q;
	bf_ctl_t bf_ctl;
	logic we;
	logic [ADDR_BITS-1:0] wr_addr, rd_addr;
	logic [WORD_BITS-1:0] wr_data, rd_data, wr_sum, wr_diff;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid || m_tready);

	// Frame position, bit-reversed store address and butterfly addressing.
	always_comb begin
		for (int b = 0; b < MAX_LG; b++)
			rev[b] = fill_q[MAX_LG-1-b];
		rev_sh = rev >> (LG_MAX - lg_q);
		nmask = {MAX_LG{1'b1}} >> (LG_MAX - lg_q);
		fill_last = (fill_q == nmask);
		half_last = (bf_q == ({HALF_BITS{1'b1}} >> (LG_MAX - lg_q)));
		stage_last = (xs_q == lg_q - LG_BITS'(1));
		kmask = ~({HALF_BITS{1'b1}} << xs_q);
		kk = bf_q & kmask;
		ii = {bf_q & ~kmask, 1'b0} | {1'b0, kk};
		jj = ii | (MAX_LG'(1) << xs_q);
		tw_idx = kk << (LG_BITS'(HALF_BITS) - xs_q);
	end

	// RAM port steering.
	always_comb begin
		we = accept;
		wr_addr = {bank_q, rev_sh};
		wr_data = {OUT_BITS'(signed'(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
			OUT_BITS'(signed'(s_tdata[SAMPLE_BITS-1:0]))};
		rd_addr = {~bank_q, fill_q};
		case (state_q)
			ST_RD_B: rd_addr = {xbank_q, jj};
			ST_RD_A: rd_addr = {xbank_q, ii};
			ST_WR_J: begin
				we = 1'b1;
				wr_addr = {xbank_q, jj};
				wr_data = wr_diff;
			end
			ST_WR_I: begin
				we = 1'b1;
				wr_addr = {xbank_q, ii};
				wr_data = wr_sum;
			end
			default: ;
		endcase
	end

	assign bf_ctl.ld_b = (state_q == ST_RD_A);
	assign bf_ctl.ld_a = (state_q == ST_MUL);
	assign bf_ctl.sum = (state_q == ST_SUM);

	// Twiddle ROM with a registered read.
	always_ff @(posedge clk) begin
		if (state_q == ST_RD_B) begin
			tw_cos_q <= TW_COS[tw_idx];
			tw_sin_q <= TW_SIN[tw_idx];
		end
	end

	r2f_mem u_mem (
		.clk     (clk),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	r2f_bfly u_bfly (
		.clk     (clk),
		.ctl     (bf_ctl),
		.rd_data (rd_data),
		.tw_cos  (tw_cos_q),
		.tw_sin  (tw_sin_q),
		.wr_sum  (wr_sum),
		.wr_diff (wr_diff)
	);

	// Sequencer, framing state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lg_q <= LG_MAX;
			fill_q <= '0;
			bank_q <= 1'b0;
			xbank_q <= 1'b0;
			have_q <= 1'b0;
			go_xf_q <= 1'b0;
			prod_s1 <= 1'b0;
			last_s1 <= 1'b0;
			idx_s1 <= '0;
			xs_q <= '0;
			bf_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tlast <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prod_s1 <= have_q;
						idx_s1 <= fill_q;
						last_s1 <= fill_last;
						xs_q <= '0;
						bf_q <= '0;
						if (fill_last) begin
							fill_q <= '0;
							bank_q <= ~bank_q;
							xbank_q <= bank_q;
							have_q <= 1'b1;
							go_xf_q <= 1'b1;
						end else begin
							fill_q <= fill_q + MAX_LG'(1);
							go_xf_q <= 1'b0;
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (prod_s1) begin
						m_tvalid <= 1'b1;
						m_tdata <= TDATA_OUT_BITS'({idx_s1, rd_data});
						m_tlast <= last_s1;
					end
					state_q <= go_xf_q ? ST_RD_B : ST_IDLE;
				end
				ST_RD_B: state_q <= ST_RD_A;
				ST_RD_A: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_WR_J;
				ST_WR_J: state_q <= ST_WR_I;
				ST_WR_I: begin
					if (half_last) begin
						bf_q <= '0;
						if (stage_last) begin
							state_q <= ST_IDLE;
						end else begin
							xs_q <= xs_q + LG_BITS'(1);
							state_q <= ST_RD_B;
						end
					end else begin
						bf_q <= bf_q + HALF_BITS'(1);
						state_q <= ST_RD_B;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// A size write restarts framing.
			if (cfg_wen) begin
				if (cfg_wdata == '0)
					lg_q <= LG_BITS'(1);
				else if (cfg_wdata > LG_MAX)
					lg_q <= LG_MAX;
				else
					lg_q <= cfg_wdata;
				fill_q <= '0;
				have_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/r2f_mem.sv
module r2f_mem (
	input  logic                           clk,
	input  logic                           we,
	input  logic [r2f_pkg::ADDR_BITS-1:0]  wr_addr,
	input  logic [r2f_pkg::WORD_BITS-1:0]  wr_data,
	input  logic [r2f_pkg::ADDR_BITS-1:0]  rd_addr,
	output logic [r2f_pkg::WORD_BITS-1:0]  rd_data
);
	import r2f_pkg::*;

	// Both sample banks, bank select in the top address bit.
	logic [WORD_BITS-1:0] mem [1 << ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/core/r2f_bfly.sv
module r2f_bfly (
	input  logic                          clk,
	input  r2f_pkg::bf_ctl_t              ctl,
	input  logic [r2f_pkg::WORD_BITS-1:0] rd_data,
	input  r2f_pkg::tw_t                  tw_cos,
	input  r2f_pkg::tw_t                  tw_sin,
	output logic [r2f_pkg::WORD_BITS-1:0] wr_sum,
	output logic [r2f_pkg::WORD_BITS-1:0] wr_diff
);
	import r2f_pkg::*;

	localparam logic signed [PROD_BITS:0] RND = (PROD_BITS+1)'(16384);

	logic [WORD_BITS-1:0] a_q, b_q;
	logic signed [OUT_BITS-1:0] a_re, a_im, b_re, b_im;
	logic signed [PROD_BITS-1:0] pcr_s1, psi_s1, pci_s1, psr_s1;
	logic signed [PROD_BITS:0] sum_re, sum_im;
	logic signed [T_BITS-1:0] tr_s2, ti_s2;
	logic signed [T_BITS:0] a_re_x, a_im_x, tr_x, ti_x;

	assign a_re = a_q[OUT_BITS-1:0];
	assign a_im = a_q[WORD_BITS-1:OUT_BITS];
	assign b_re = b_q[OUT_BITS-1:0];
	assign b_im = b_q[WORD_BITS-1:OUT_BITS];

	// Operand capture and the four twiddle products.
	always_ff @(posedge clk) begin
		if (ctl.ld_b)
			b_q <= rd_data;
		if (ctl.ld_a) begin
			a_q <= rd_data;
			pcr_s1 <= tw_cos * b_re;
			psi_s1 <= tw_sin * b_im;
			pci_s1 <= tw_cos * b_im;
			psr_s1 <= tw_sin * b_re;
		end
	end

	// Product sums rounded half up to the Q15 grid.
	always_comb begin
		sum_re = (PROD_BITS+1)'(pcr_s1) + (PROD_BITS+1)'(psi_s1) + RND;
		sum_im = (PROD_BITS+1)'(pci_s1) - (PROD_BITS+1)'(psr_s1) + RND;
	end

	always_ff @(posedge clk) begin
		if (ctl.sum) begin
			tr_s2 <= sum_re[PROD_BITS:15];
			ti_s2 <= sum_im[PROD_BITS:15];
		end
	end

	// Sum and difference legs, each saturated.
	always_comb begin
		a_re_x = (T_BITS+1)'(a_re);
		a_im_x = (T_BITS+1)'(a_im);
		tr_x = (T_BITS+1)'(tr_s2);
		ti_x = (T_BITS+1)'(ti_s2);
		wr_sum = {sat_out(a_im_x + ti_x), sat_out(a_re_x + tr_x)};
		wr_diff = {sat_out(a_im_x - ti_x), sat_out(a_re_x - tr_x)};
	end

endmodule

FILE: rtl/core/r2f_chk.sv
`include "radix2_fft_frame_macros.svh"

module r2f_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [r2f_pkg::TDATA_IN_BITS-1:0]  s_tdata,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [r2f_pkg::TDATA_OUT_BITS-1:0] m_tdata,
	input logic                               m_tlast,
	input logic                               cfg_wen,
	input logic [r2f_pkg::LG_BITS-1:0]        cfg_wdata
);
	import r2f_pkg::*;

	`R2F_ASSERT_ALWAYS(a_no_bin_in_reset, !arst_n |-> !m_tvalid, "bin shown during reset")
	`R2F_ASSERT(a_bin_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled bin changed")
	`R2F_ASSERT(a_no_take_while_full, m_tvalid && !m_tready |-> !s_tready, "sample taken over a waiting bin")
	`R2F_ASSERT(a_bin_from_request, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "bin without a request")

endmodule

bind radix2_fft_frame r2f_chk u_chk (.*);

FILE: test/radix2_fft_frame_tb.sv
`timescale 1ns / 1ps

module radix2_fft_frame_tb;
	import r2f_pkg::*;

	localparam int MAX_PTS = 1 << MAX_LG;
	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct {
		logic signed [OUT_BITS-1:0] re;
		logic signed [OUT_BITS-1:0] im;
		logic [MAX_LG-1:0] index;
		logic last;
	} fft_bin_t;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
	} sample_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [TDATA_IN_BITS-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [TDATA_OUT_BITS-1:0] m_tdata;
	logic m_tlast;
	logic cfg_wen;
	logic [LG_BITS-1:0] cfg_wdata;

	radix2_fft_frame dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the block's state.
	longint bank_re [2][MAX_PTS];
	longint bank_im [2][MAX_PTS];
	int unsigned fill_count;
	int unsigned bank_sel;
	bit have_frame;
	int unsigned cur_lg;

	fft_bin_t pending_bins[$];
	int errors;
	int mismatches;
	int samples_sent;
	int bins_checked;
	int frames_done;
	int quiet_cycles;
	bit idle_on;
	int stall_left;

	// Directed samples: extremes, zero and small values of both parts, walked at two points per frame.
	sample_t directed_rows [20] = '{
		'{16'sh7FFF, 16'sh7FFF}, '{16'sh7FFF, 16'sh7FFF},
		'{-16'sh8000, -16'sh8000}, '{-16'sh8000, -16'sh8000},
		'{16'sh7FFF, -16'sh8000}, '{-16'sh8000, 16'sh7FFF},
		'{16'sh0000, 16'sh0000}, '{16'sh0000, 16'sh0000},
		'{16'sh0001, 16'sh0000}, '{16'sh0000, 16'sh0001},
		'{-16'sh0001, -16'sh0001}, '{16'sh0001, 16'sh0001},
		'{16'sh5555, 16'shAAAA}, '{16'shAAAA, 16'sh5555},
		'{16'sh7FFF, 16'sh0000}, '{-16'sh8000, 16'sh0000},
		'{16'sh0000, 16'sh7FFF}, '{16'sh0000, -16'sh8000},
		'{16'sh1234, -16'sh4321}, '{16'sh7FFF, -16'sh8000}
	};

	// Clock: 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint mul_q30(longint a, longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic longint to_q15(longint v);
		longint q;
		q = (v + 16384) >>> 15;
		return (q > 32767) ? 32767 : q;
	endfunction

	// Cosine and sine in Q15 of 2*pi*r/65536, r within the first octant.
	function automatic void octant_cos_sin(longint r, output longint c, output longint s);
		longint x, x2, x3, x4, x5, x6, x7, x8, x9;
		x = (r * TWO_PI_Q30 + 32768) >>> 16;
		x2 = mul_q30(x, x);
		x3 = mul_q30(x2, x);
		x4 = mul_q30(x2, x2);
		x5 = mul_q30(x4, x);
		x6 = mul_q30(x4, x2);
		x7 = mul_q30(x6, x);
		x8 = mul_q30(x4, x4);
		x9 = mul_q30(x8, x);
		c = to_q15((64'sd1 <<< 30) - x2 / 2 + x4 / 24 - x6 / 720 + x8 / 40320);
		s = to_q15(x - x3 / 6 + x5 / 120 - x7 / 5040 + x9 / 362880);
	endfunction

	// Twiddle cosine and sine for a 16-bit phase in the upper half plane.
	function automatic void twiddle(longint ph, output longint c, output longint s);
		longint r, oc, os, cr, sr;
		r = ph & 64'h3FFF;
		if (r > 64'h2000) begin
			octant_cos_sin(64'h4000 - r, oc, os);
			cr = os;
			sr = oc;
		end else begin
			octant_cos_sin(r, cr, sr);
		end
		if (ph[14]) begin
			c = -sr;
			s = cr;
		end else begin
			c = cr;
			s = sr;
		end
	endfunction

	function automatic longint clamp_out(longint v);
		longint hi;
		hi = (64'sd1 <<< (OUT_BITS - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	function automatic int unsigned reverse_bits(int unsigned v, int unsigned nbits);
		int unsigned r;
		r = 0;
		for (int i = 0; i < nbits; i++)
			r = (r << 1) | ((v >> i) & 1);
		return r;
	endfunction

	// In-place decimation-in-time butterflies over one bank.
	function automatic void run_fft(int unsigned b, int unsigned lg);
		int unsigned n, span, j;
		longint c, s, xr, xi, tr, ti, ar, ai;
		n = 1 << lg;
		for (int unsigned st = 0; st < lg; st++) begin
			span = 1 << st;
			for (int unsigned k = 0; k < span; k++) begin
				twiddle(longint'(k) << (15 - st), c, s);
				for (int unsigned i = k; i < n; i += 2 * span) begin
					j = i + span;
					xr = bank_re[b][j];
					xi = bank_im[b][j];
					tr = (c * xr + s * xi + 16384) >>> 15;
					ti = (c * xi - s * xr + 16384) >>> 15;
					ar = bank_re[b][i];
					ai = bank_im[b][i];
					bank_re[b][j] = clamp_out(ar - tr);
					bank_im[b][j] = clamp_out(ai - ti);
					bank_re[b][i] = clamp_out(ar + tr);
					bank_im[b][i] = clamp_out(ai + ti);
				end
			end
		end
	endfunction

	// Stores one accepted sample and queues the bin it returns, if any.
	function automatic void predict_bin(logic [TDATA_IN_BITS-1:0] data);
		int unsigned n, fb, addr;
		fft_bin_t bin;
		n = 1 << cur_lg;
		fb = bank_sel;
		addr = reverse_bits(fill_count, cur_lg);
		bank_re[fb][addr] = longint'($signed(data[SAMPLE_BITS-1:0]));
		bank_im[fb][addr] = longint'($signed(data[2*SAMPLE_BITS-1:SAMPLE_BITS]));
		if (have_frame) begin
			bin.re = bank_re[fb ^ 1][fill_count][OUT_BITS-1:0];
			bin.im = bank_im[fb ^ 1][fill_count][OUT_BITS-1:0];
			bin.index = fill_count[MAX_LG-1:0];
			bin.last = (fill_count + 1 == n);
			pending_bins.push_back(bin);
		end
		fill_count++;
		if (fill_count >= n) begin
			run_fft(fb, cur_lg);
			bank_sel = fb ^ 1;
			have_frame = 1'b1;
			fill_count = 0;
			frames_done++;
		end
	endfunction

	function automatic void set_size(logic [LG_BITS-1:0] v);
		cur_lg = (v < 1) ? 1 : ((v > MAX_LG) ? MAX_LG : v);
		fill_count = 0;
		have_frame = 1'b0;
	endfunction

	// Monitor: updates the predictor on input requests and checks output requests.
	always @(posedge clk) begin
		fft_bin_t want;
		fft_bin_t got;
		if (arst_n) begin
			if (cfg_wen)
				set_size(cfg_wdata);
			if (s_tvalid && s_tready)
				predict_bin(s_tdata);
			if (m_tvalid && m_tready) begin
				got.re = m_tdata[OUT_BITS-1:0];
				got.im = m_tdata[2*OUT_BITS-1:OUT_BITS];
				got.index = m_tdata[2*OUT_BITS+MAX_LG-1:2*OUT_BITS];
				got.last = m_tlast;
				if (pending_bins.size() == 0) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected bin index %0d re %0d im %0d",
							got.index, got.re, got.im);
				end else begin
					want = pending_bins.pop_front();
					bins_checked++;
					if (got.re !== want.re || got.im !== want.im ||
						got.index !== want.index || got.last !== want.last) begin
						errors++;
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: bin expected idx %0d re %0d im %0d last %0d, got idx %0d re %0d im %0d last %0d",
								want.index, want.re, want.im, want.last,
								got.index, got.re, got.im, got.last);
					end
				end
			end
			// Watchdog on cycles without any accepted request.
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired, %0d bins still expected", pending_bins.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts while idling is enabled.
	always @(negedge clk) begin
		if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 10);
		m_tready <= (stall_left == 0);
		if (stall_left > 0)
			stall_left--;
	end

	// Sends one sample, waiting for the request to be taken.
	task automatic send_sample(logic [SAMPLE_BITS-1:0] re, logic [SAMPLE_BITS-1:0] im);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {im, re};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		samples_sent++;
	endtask

	// Waits until the block is idle, then writes the size register.
	task automatic write_size(logic [LG_BITS-1:0] v);
		s_tvalid <= 1'b0;
		while (pending_bins.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (!s_tready)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_part();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return SAMPLE_BITS'($signed($urandom_range(0, 64)) - 32);
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// Random phase: count samples at one size; a frame may be flagged constant.
	task automatic run_phase(logic [LG_BITS-1:0] size_reg, int count, bit first_frame_min);
		int unsigned n;
		write_size(size_reg);
		n = 1 << ((size_reg < 1) ? 1 : ((size_reg > MAX_LG) ? MAX_LG : size_reg));
		for (int i = 0; i < count; i++) begin
			if (first_frame_min && i < n)
				send_sample(16'h8000, 16'h8000);
			else
				send_sample(pick_part(), pick_part());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		errors = 0;
		mismatches = 0;
		samples_sent = 0;
		bins_checked = 0;
		frames_done = 0;
		quiet_cycles = 0;
		stall_left = 0;
		idle_on = 1'b1;
		fill_count = 0;
		bank_sel = 0;
		have_frame = 1'b0;
		cur_lg = 10;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A few samples at the reset size, then a size write restarts framing.
		for (int i = 0; i < 5; i++)
			send_sample(pick_part(), pick_part());

		// Directed extremes at the smallest size; a zero write counts as one.
		write_size(4'd0);
		foreach (directed_rows[i])
			send_sample(directed_rows[i].re, directed_rows[i].im);

		// Random phases across sizes, ending frames early in some.
		run_phase(4'd2, 40, 1'b0);
		run_phase(4'd3, 40, 1'b0);
		run_phase(4'd4, 48, 1'b0);
		run_phase(4'd5, 70, 1'b0);
		// A whole frame of the most negative sample in both parts.
		run_phase(4'd7, 150, 1'b1);
		idle_on = 1'b0;
		run_phase(4'd1, 30, 1'b0);
		run_phase(4'd8, 300, 1'b0);

		s_tvalid <= 1'b0;
		while (pending_bins.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d samples over sizes 2 to 256 points, %0d frames transformed,",
			samples_sent, frames_done);
		$display("%0d bins checked, %0d mismatches", bins_checked, mismatches);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
